// File: hdl/ibd_pkg.sv
// ---------------------------------------------------------------------------
// ibd_pkg
// types, constants and helpers shared by the image downscaler modules
// ---------------------------------------------------------------------------
package ibd_pkg;

  localparam int MAX_IN_WIDTH  = 2048;
  localparam int MAX_OUT_WIDTH = 1024;
  localparam int MAX_FACTOR    = 8;
  localparam int HEIGHT_CAP    = 4096;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int FACTOR_W = 4;
  localparam int CFG_W    = 13;
  localparam int COL_W    = 11;
  localparam int ROW_W    = 12;
  localparam int PHASE_W  = 3;
  localparam int BC_W     = $clog2(MAX_OUT_WIDTH);
  localparam int ADD_W    = PIX_W + 2;
  localparam int SUM_W    = 14;
  localparam int Q9_W     = SUM_W - 2;
  localparam int RECIP9_W = 13;
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int RES_DEPTH = 2;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  // floor(x/9) = (x * RECIP9) >> 16 for every x below 2^Q9_W
  localparam logic [RECIP9_W-1:0] RECIP9 = RECIP9_W'(7282);

  typedef enum logic [1:0] {
    REG_IN_WIDTH     = 2'd0,
    REG_IN_HEIGHT    = 2'd1,
    REG_SCALE_FACTOR = 2'd2,
    REG_COLOR_MODE   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_or_gray;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_or_gray_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             frame_end;
  } out_item_t;

  // saturated configuration
  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [FACTOR_W-1:0] factor;
    logic                odd;
  } cfg_t;

  typedef struct packed {
    logic [ADD_W-1:0] r;
    logic [ADD_W-1:0] g;
    logic [ADD_W-1:0] b;
  } add_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } sum_t;

  // one pixel request from front to back
  typedef struct packed {
    add_t            add;
    logic [BC_W-1:0] bc;
    logic            seg_first;
    logic            seg_last;
    logic            row_first;
    logic            emit;
    logic            frame_end;
  } cmd_t;

  function automatic logic [PIX_W-1:0] scale_sum(input logic [SUM_W-1:0] s,
                                                 input logic [FACTOR_W-1:0] f,
                                                 input logic odd);
    logic [Q9_W-1:0]          q;
    logic [Q9_W+RECIP9_W-1:0] prod;
    logic [SUM_W-1:0]         v;
    q    = s[SUM_W-1:2];
    prod = (Q9_W+RECIP9_W)'(q) * (Q9_W+RECIP9_W)'(RECIP9);
    if (odd) begin
      v = s >> 4;
    end else begin
      case (f)
        FACTOR_W'(2): v = s >> 2;
        FACTOR_W'(4): v = s >> 4;
        FACTOR_W'(6): v = SUM_W'(prod >> 16);
        default:      v = s >> 6;
      endcase
    end
    return v[PIX_W-1:0];
  endfunction

endpackage

// File: hdl/ibd_front.sv
// ---------------------------------------------------------------------------
// ibd_front
// tracks raster position and block phase, weights pixels, issues requests
// ---------------------------------------------------------------------------
module ibd_front (
  input  logic             clk,
  input  logic             rst,
  input  ibd_pkg::cfg_t    cfg,
  input  logic             restart,
  input  logic             accept,
  input  ibd_pkg::in_item_t pixel,
  input  logic             color,
  output logic             cmd_push,
  output ibd_pkg::cmd_t    cmd
);

  logic [ibd_pkg::COL_W-1:0]   c, c_next;
  logic [ibd_pkg::ROW_W-1:0]   r, r_next;
  logic [ibd_pkg::PHASE_W-1:0] cp, cp_next, rp, rp_next;
  logic [ibd_pkg::COL_W-1:0]   cs, cs_next;
  logic [ibd_pkg::ROW_W-1:0]   rs, rs_next;
  logic [ibd_pkg::BC_W-1:0]    bc, bc_next;

  logic [ibd_pkg::HEIGHT_W-1:0] f13;
  logic                         col_ok, row_ok, col_last, row_last;
  logic                         cp_wrap, rp_wrap;
  logic [1:0]                   sh;
  logic                         wt_zero;
  logic [ibd_pkg::PIX_W-1:0]    g_pix, b_pix;

  always_comb begin
    f13      = ibd_pkg::HEIGHT_W'(cfg.factor);
    col_ok   = (ibd_pkg::HEIGHT_W'(cs) + f13) <= ibd_pkg::HEIGHT_W'(cfg.width);
    row_ok   = (ibd_pkg::HEIGHT_W'(rs) + f13) <= cfg.height;
    col_last = (ibd_pkg::HEIGHT_W'(cs) + (f13 << 1)) > ibd_pkg::HEIGHT_W'(cfg.width);
    row_last = (ibd_pkg::HEIGHT_W'(rs) + (f13 << 1)) > cfg.height;
    cp_wrap  = (ibd_pkg::FACTOR_W'(cp) + 1'b1) >= cfg.factor;
    rp_wrap  = (ibd_pkg::FACTOR_W'(rp) + 1'b1) >= cfg.factor;

    // 1-2-1 weights as shifts, zero outside the top-left 3x3
    sh      = cfg.odd ? (2'(rp == 3'd1) + 2'(cp == 3'd1)) : 2'd0;
    wt_zero = cfg.odd && (cp >= 3'd3 || rp >= 3'd3);
    g_pix   = color ? pixel.green_in : '0;
    b_pix   = color ? pixel.blue_in : '0;

    cmd.add.r     = wt_zero ? '0 : (ibd_pkg::ADD_W'(pixel.red_or_gray) << sh);
    cmd.add.g     = wt_zero ? '0 : (ibd_pkg::ADD_W'(g_pix) << sh);
    cmd.add.b     = wt_zero ? '0 : (ibd_pkg::ADD_W'(b_pix) << sh);
    cmd.bc        = bc;
    cmd.seg_first = (cp == '0);
    cmd.seg_last  = cp_wrap;
    cmd.row_first = (rp == '0);
    cmd.emit      = cp_wrap && rp_wrap;
    cmd.frame_end = col_last && row_last;
    cmd_push      = accept && col_ok && row_ok;

    c_next  = c;
    r_next  = r;
    cp_next = cp;
    rp_next = rp;
    cs_next = cs;
    rs_next = rs;
    bc_next = bc;
    if ((ibd_pkg::WIDTH_W'(c) + 1'b1) >= cfg.width) begin
      c_next  = '0;
      cp_next = '0;
      cs_next = '0;
      bc_next = '0;
      if ((ibd_pkg::HEIGHT_W'(r) + 1'b1) >= cfg.height) begin
        r_next  = '0;
        rp_next = '0;
        rs_next = '0;
      end else begin
        r_next = r + 1'b1;
        if (rp_wrap) begin
          rp_next = '0;
          rs_next = r + 1'b1;
        end else begin
          rp_next = rp + 1'b1;
        end
      end
    end else begin
      c_next = c + 1'b1;
      if (cp_wrap) begin
        cp_next = '0;
        cs_next = c + 1'b1;
        bc_next = bc + 1'b1;
      end else begin
        cp_next = cp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      c  <= '0;
      r  <= '0;
      cp <= '0;
      rp <= '0;
      cs <= '0;
      rs <= '0;
      bc <= '0;
    end else if (accept) begin
      c  <= c_next;
      r  <= r_next;
      cp <= cp_next;
      rp <= rp_next;
      cs <= cs_next;
      rs <= rs_next;
      bc <= bc_next;
    end
  end

endmodule

// File: hdl/ibd_cmd_fifo.sv
// ---------------------------------------------------------------------------
// ibd_cmd_fifo
// short request queue between front and back
// ---------------------------------------------------------------------------
module ibd_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  ibd_pkg::cmd_t wdata,
  input  logic          rd,
  output ibd_pkg::cmd_t rdata,
  output logic          full,
  output logic          empty
);

  ibd_pkg::cmd_t                  store [ibd_pkg::CMD_DEPTH];
  logic [ibd_pkg::CMD_PTR_W-1:0]  wptr, rptr;
  logic [ibd_pkg::CMD_PTR_W:0]    count;

  assign full  = (count == (ibd_pkg::CMD_PTR_W+1)'(ibd_pkg::CMD_DEPTH));
  assign empty = (count == '0);
  assign rdata = store[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      store[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (ibd_pkg::CMD_PTR_W+1)'(wr) - (ibd_pkg::CMD_PTR_W+1)'(rd);
    end
  end

endmodule

// File: hdl/ibd_back.sv
// ---------------------------------------------------------------------------
// ibd_back
// row segment sums, column accumulator memory, scaling and result queue
// ---------------------------------------------------------------------------
module ibd_back (
  input  logic                clk,
  input  logic                rst,
  input  ibd_pkg::cfg_t       cfg,
  input  ibd_pkg::cmd_t       cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output logic                empty,
  input  logic                pop,
  output ibd_pkg::out_item_t  result
);

  logic [3*ibd_pkg::SUM_W-1:0] col_mem [ibd_pkg::MAX_OUT_WIDTH];
  ibd_pkg::sum_t               rdata;

  ibd_pkg::sum_t               hsum, hsum_next;
  logic                        s2_valid, s2_row_first, s2_emit, s2_frame_end;
  ibd_pkg::sum_t               s2_sum, total;
  logic [ibd_pkg::BC_W-1:0]    s2_bc;
  logic                        s2_fire;

  ibd_pkg::out_item_t          res_q [ibd_pkg::RES_DEPTH];
  logic [ibd_pkg::RES_PTR_W-1:0] res_wr, res_rd;
  logic [ibd_pkg::RES_PTR_W:0]   res_count;
  logic                        res_full, res_push, res_pop;
  ibd_pkg::out_item_t          res_new;

  always_comb begin
    res_full = (res_count == (ibd_pkg::RES_PTR_W+1)'(ibd_pkg::RES_DEPTH));
    s2_fire  = s2_valid && (!s2_emit || !res_full);
    cmd_pop  = !cmd_empty && (!s2_valid || s2_fire);

    if (cmd.seg_first) begin
      hsum_next.r = ibd_pkg::SUM_W'(cmd.add.r);
      hsum_next.g = ibd_pkg::SUM_W'(cmd.add.g);
      hsum_next.b = ibd_pkg::SUM_W'(cmd.add.b);
    end else begin
      hsum_next.r = hsum.r + ibd_pkg::SUM_W'(cmd.add.r);
      hsum_next.g = hsum.g + ibd_pkg::SUM_W'(cmd.add.g);
      hsum_next.b = hsum.b + ibd_pkg::SUM_W'(cmd.add.b);
    end

    if (s2_row_first) begin
      total = s2_sum;
    end else begin
      total.r = s2_sum.r + rdata.r;
      total.g = s2_sum.g + rdata.g;
      total.b = s2_sum.b + rdata.b;
    end

    res_new.red_or_gray_out = ibd_pkg::scale_sum(total.r, cfg.factor, cfg.odd);
    res_new.green_out       = ibd_pkg::scale_sum(total.g, cfg.factor, cfg.odd);
    res_new.blue_out        = ibd_pkg::scale_sum(total.b, cfg.factor, cfg.odd);
    res_new.frame_end       = s2_frame_end;

    res_push = s2_fire && s2_emit;
    res_pop  = pop && !empty;
  end

  // column accumulators, registered read
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      col_mem[s2_bc] <= total;
    end
    if (cmd_pop && cmd.seg_last) begin
      rdata <= col_mem[cmd.bc];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      hsum <= hsum_next;
      if (cmd.seg_last) begin
        s2_sum       <= hsum_next;
        s2_bc        <= cmd.bc;
        s2_row_first <= cmd.row_first;
        s2_emit      <= cmd.emit;
        s2_frame_end <= cmd.frame_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (cmd_pop) begin
      s2_valid <= cmd.seg_last;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  // result queue
  assign empty  = (res_count == '0);
  assign result = res_q[res_rd];

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q[res_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= '0;
      res_rd    <= '0;
      res_count <= '0;
    end else begin
      if (res_push) begin
        res_wr <= res_wr + 1'b1;
      end
      if (res_pop) begin
        res_rd <= res_rd + 1'b1;
      end
      res_count <= res_count + (ibd_pkg::RES_PTR_W+1)'(res_push)
                             - (ibd_pkg::RES_PTR_W+1)'(res_pop);
    end
  end

endmodule

// File: hdl/image_block_downscale.sv
// ---------------------------------------------------------------------------
// image_block_downscale
// raster image downscaler: block mean for even factors, 3x3 gaussian for odd
// ---------------------------------------------------------------------------
//  channel   ports                           handshake
//  pixels    push, full, pixel               accepted on push & !full
//  results   empty, pop, result              accepted on pop & !empty
//  config    cfg_write, cfg_index, cfg_data  written on cfg_write
//
//  one pixel per cycle while full is low; after the last pixel of its block,
//  a result passes the request queue, the column memory read and the result queue
//  rst is synchronous; any register write restarts the frame position
//  full rises when the four-entry request queue fills behind a stalled
//  two-entry result queue
module image_block_downscale (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  ibd_pkg::in_item_t         pixel,
  output logic                      empty,
  input  logic                      pop,
  output ibd_pkg::out_item_t        result,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [ibd_pkg::CFG_W-1:0] cfg_data
);

  logic [ibd_pkg::WIDTH_W-1:0]  reg_width;
  logic [ibd_pkg::HEIGHT_W-1:0] reg_height;
  logic [ibd_pkg::FACTOR_W-1:0] reg_factor;
  logic                         reg_color;
  ibd_pkg::cfg_t                cfg;

  logic          accept;
  logic          cmd_push, cmd_pop, cmd_full, cmd_empty;
  ibd_pkg::cmd_t cmd_in, cmd_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= ibd_pkg::WIDTH_W'(2048);
      reg_height <= ibd_pkg::HEIGHT_W'(2048);
      reg_factor <= ibd_pkg::FACTOR_W'(2);
      reg_color  <= 1'b1;
    end else if (cfg_write) begin
      case (ibd_pkg::reg_index_t'(cfg_index))
        ibd_pkg::REG_IN_WIDTH:     reg_width  <= cfg_data[ibd_pkg::WIDTH_W-1:0];
        ibd_pkg::REG_IN_HEIGHT:    reg_height <= cfg_data[ibd_pkg::HEIGHT_W-1:0];
        ibd_pkg::REG_SCALE_FACTOR: reg_factor <= cfg_data[ibd_pkg::FACTOR_W-1:0];
        ibd_pkg::REG_COLOR_MODE:   reg_color  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (reg_width == '0) begin
      cfg.width = ibd_pkg::WIDTH_W'(1);
    end else if (reg_width > ibd_pkg::WIDTH_W'(ibd_pkg::MAX_IN_WIDTH)) begin
      cfg.width = ibd_pkg::WIDTH_W'(ibd_pkg::MAX_IN_WIDTH);
    end else begin
      cfg.width = reg_width;
    end
    if (reg_height == '0) begin
      cfg.height = ibd_pkg::HEIGHT_W'(1);
    end else if (reg_height > ibd_pkg::HEIGHT_W'(ibd_pkg::HEIGHT_CAP)) begin
      cfg.height = ibd_pkg::HEIGHT_W'(ibd_pkg::HEIGHT_CAP);
    end else begin
      cfg.height = reg_height;
    end
    if (reg_factor < ibd_pkg::FACTOR_W'(2)) begin
      cfg.factor = ibd_pkg::FACTOR_W'(2);
    end else if (reg_factor > ibd_pkg::FACTOR_W'(ibd_pkg::MAX_FACTOR)) begin
      cfg.factor = ibd_pkg::FACTOR_W'(ibd_pkg::MAX_FACTOR);
    end else begin
      cfg.factor = reg_factor;
    end
    cfg.odd = cfg.factor[0];
  end

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  ibd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .restart  (cfg_write),
    .accept   (accept),
    .pixel    (pixel),
    .color    (reg_color),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  ibd_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_in),
    .rd    (cmd_pop),
    .rdata (cmd_out),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  ibd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("request pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("request popped from empty queue");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> accept)
    else $error("request issued without an accepted pixel");

endmodule
